// ----- hw/rtl/sfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    // Frame layout
    localparam int unsigned BufferBytes = 128;
    localparam int unsigned PosW        = 8;
    localparam int unsigned SizeW       = 9;
    localparam int unsigned IndexW      = 7;
    localparam int unsigned ByteW       = 8;

    localparam logic [ByteW-1:0] HdrByte     = 8'hBB;
    localparam logic [ByteW-1:0] CmdStatus   = 8'h04;
    localparam logic [ByteW-1:0] CmdResponse = 8'h03;
    localparam logic [ByteW-1:0] FixedOne    = 8'h01;
    localparam logic [ByteW-1:0] FixedZero   = 8'h00;
    localparam logic [ByteW-1:0] FixedFour   = 8'h04;
    localparam logic [SizeW-1:0] LenExtra    = 9'd6;
    localparam logic [SizeW-1:0] MinSize     = 9'd8;
    localparam logic [SizeW-1:0] MaxSize     = SizeW'(BufferBytes);

    // Offsets within a frame
    localparam logic [PosW-1:0] OffVersion = 8'd1;
    localparam logic [PosW-1:0] OffPad     = 8'd2;
    localparam logic [PosW-1:0] OffCommand = 8'd3;
    localparam logic [PosW-1:0] OffLength  = 8'd4;
    localparam logic [PosW-1:0] OffKind    = 8'd5;
    localparam logic [PosW-1:0] OffKindPad = 8'd6;

    // Supported frame sizes
    localparam logic [SizeW-1:0] SizeA = 9'd61;
    localparam logic [SizeW-1:0] SizeB = 9'd65;
    localparam logic [SizeW-1:0] SizeC = 9'd68;

    // Configuration register indexes
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = 3;
    localparam logic [CfgIdxW-1:0] CfgDeviceProfile  = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgAcceptResponse = 1'b1;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_GOOD   = 2'd1,
        ST_REJECT = 2'd2,
        ST_ABORT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RSN_NONE     = 3'd0,
        RSN_SIZE     = 3'd1,
        RSN_FIXED    = 3'd2,
        RSN_COMMAND  = 3'd3,
        RSN_CHECKSUM = 3'd4
    } reason_t;

    typedef struct packed {
        logic [2:0] device_profile;
        logic       accept_response;
    } cfg_t;

    typedef struct packed {
        status_t                status;
        reason_t                reject_reason;
        logic                   in_frame;
        logic [IndexW-1:0]      byte_index;
        logic [ByteW-1:0]       data_out;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfr_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sfr_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [sfr_pkg::CfgDataW-1:0]   cfg_data,
    output sfr_pkg::cfg_t                       cfg
);
    import sfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode a write beat into the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CfgDeviceProfile:  cfg_next.device_profile  = cfg_data[2:0];
                CfgAcceptResponse: cfg_next.accept_response = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sfr_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfr_parser (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire logic [sfr_pkg::ByteW-1:0]  rx_byte,
    input  sfr_pkg::cfg_t                   cfg,
    output sfr_pkg::result_t                result
);
    import sfr_pkg::*;

    logic [PosW-1:0]  position_reg,  position_next;
    logic [SizeW-1:0] frame_size_reg, frame_size_next;
    logic [ByteW-1:0] xor_reg,       xor_next;
    logic             fixed_err_reg, fixed_err_next;
    logic             cmd_err_reg,   cmd_err_next;

    logic [SizeW-1:0] len_size;
    logic [SizeW-1:0] size_eff;
    logic [SizeW-1:0] pos_inc;
    logic             fixed_bad;
    logic             cmd_ok;
    logic             len_bad;
    logic             size_ok;

    assign len_size = {1'b0, rx_byte} + LenExtra;
    assign pos_inc  = {1'b0, position_reg} + 9'd1;
    assign len_bad  = (len_size < MinSize) || (len_size > MaxSize);
    assign cmd_ok   = (rx_byte == CmdStatus) ||
                      ((rx_byte == CmdResponse) &&
                       ((cfg.device_profile != 3'd0) || cfg.accept_response));
    assign fixed_bad = ((position_reg == OffVersion) && (rx_byte != FixedOne))  ||
                       ((position_reg == OffPad)     && (rx_byte != FixedZero)) ||
                       ((position_reg == OffKind)    && (rx_byte != FixedFour)) ||
                       ((position_reg == OffKindPad) && (rx_byte != FixedZero));
    assign size_eff = (position_reg == OffLength) ? len_size : frame_size_reg;
    assign size_ok  = (size_eff == SizeA) || (size_eff == SizeB) || (size_eff == SizeC);

    // Per-byte parse: next state and the result for this beat
    always_comb begin
        position_next   = position_reg;
        frame_size_next = frame_size_reg;
        xor_next        = xor_reg;
        fixed_err_next  = fixed_err_reg;
        cmd_err_next    = cmd_err_reg;

        result.status        = ST_NONE;
        result.reject_reason = RSN_NONE;
        result.in_frame      = 1'b0;
        result.byte_index    = '0;
        result.data_out      = rx_byte;

        if (position_reg == '0) begin
            // Hunt for the header
            if (rx_byte == HdrByte) begin
                position_next   = 8'd1;
                frame_size_next = '0;
                xor_next        = HdrByte;
                fixed_err_next  = 1'b0;
                cmd_err_next    = 1'b0;
                result.in_frame = 1'b1;
            end
        end else begin
            result.in_frame   = 1'b1;
            result.byte_index = position_reg[IndexW-1:0];
            fixed_err_next    = fixed_err_reg | fixed_bad;
            if (position_reg == OffCommand) begin
                cmd_err_next = cmd_err_reg | !cmd_ok;
            end

            if ((position_reg == OffLength) && len_bad) begin
                // Drop the frame on an impossible length
                result.status   = ST_ABORT;
                position_next   = '0;
                frame_size_next = '0;
                xor_next        = '0;
                fixed_err_next  = 1'b0;
                cmd_err_next    = 1'b0;
            end else if ((size_eff != '0) && (pos_inc == size_eff)) begin
                // Last byte: judge the frame, then go back to hunting
                if (!size_ok) begin
                    result.reject_reason = RSN_SIZE;
                end else if (fixed_err_next) begin
                    result.reject_reason = RSN_FIXED;
                end else if (cmd_err_next) begin
                    result.reject_reason = RSN_COMMAND;
                end else if (xor_reg != rx_byte) begin
                    result.reject_reason = RSN_CHECKSUM;
                end
                result.status   = (result.reject_reason != RSN_NONE) ? ST_REJECT : ST_GOOD;
                position_next   = '0;
                frame_size_next = '0;
                xor_next        = '0;
                fixed_err_next  = 1'b0;
                cmd_err_next    = 1'b0;
            end else begin
                // Advance within the frame
                frame_size_next = size_eff;
                xor_next        = xor_reg ^ rx_byte;
                position_next   = pos_inc[PosW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            frame_size_reg <= '0;
            xor_reg        <= '0;
            fixed_err_reg  <= 1'b0;
            cmd_err_reg    <= 1'b0;
        end else if (step) begin
            position_reg   <= position_next;
            frame_size_reg <= frame_size_next;
            xor_reg        <= xor_next;
            fixed_err_reg  <= fixed_err_next;
            cmd_err_reg    <= cmd_err_next;
        end
    end

`ifndef SYNTH
    // A frame outcome is only ever reported for a byte inside a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (result.status != ST_NONE) |-> result.in_frame)
        else $error("sfr_parser: outcome reported outside a frame");

    // A reason is given exactly when the frame is rejected
    assert property (@(posedge aclk) disable iff (!aresetn)
        (result.status == ST_REJECT) == (result.reject_reason != RSN_NONE))
        else $error("sfr_parser: reject reason does not match status");

    // Any frame outcome sends the parser back to hunting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (result.status != ST_NONE)) |=> (position_reg == '0))
        else $error("sfr_parser: not hunting after a completed frame");

    // A learned frame size never exceeds the buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_size_reg <= MaxSize)
        else $error("sfr_parser: frame size above buffer capacity");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/status_frame_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Status frame receiver. Takes one UART byte per beat on the s_ channel and
// returns exactly one result beat per byte on the m_ channel: the byte itself,
// its offset in the current frame, and on the last byte of a frame (or on a bad
// length byte at offset 4) the frame verdict. Frames start with 0xBB; the
// length byte plus 6 gives the frame size, and a frame is judged on size,
// fixed bytes, command and XOR checksum. The block sustains one byte per clock
// cycle while m_tready stays high. Each byte passes through an input register
// and then a result register; its result is offered on m_tvalid from the result
// register and held there until m_tready takes it.
// s_tready falls only while both registers hold beats and m_tready is low.
// Write device_profile (index 0) and accept_response (index 1) while no bytes
// are in flight.
module status_frame_receiver (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] rx_byte

    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [23:0]                         m_tdata,   // [2:0] reject_reason,
                                                           // [9:3] byte_index,
                                                           // [17:10] data_out, rest zero
    output logic [2:0]                          m_tuser,   // [1:0] status, [2] in_frame

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sfr_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [sfr_pkg::CfgDataW-1:0]   cfg_data
);
    import sfr_pkg::*;

    cfg_t             cfg;
    result_t          result;
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    sfr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance && in_valid_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register: take a beat whenever the stage frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Result register: hold until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.data_out, out_reg.byte_index, out_reg.reject_reason};
    assign m_tuser  = {out_reg.in_frame, out_reg.status};

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import sfr_pkg::*;

    localparam int unsigned StallLimit  = 5000;
    localparam int unsigned NumPhases   = 5;
    localparam int unsigned PhaseBytes  = 50;
    localparam int unsigned SettleGap   = 4;
    localparam int unsigned TailCycles  = 10;
    localparam int unsigned LongHold    = 45;
    localparam int unsigned ReportMax   = 10;
    localparam int unsigned HoldAt [2]  = '{150, 450};

    localparam logic [2:0]          PhaseProfile [NumPhases] = '{3'd0, 3'd0, 3'd4, 3'd7, 3'd0};
    localparam logic [CfgDataW-1:0] PhaseAccept  [NumPhases] = '{3'd0, 3'd1, 3'd1, 3'd0, 3'd0};
    localparam int unsigned         SendIdle     [NumPhases] = '{11, 11, 58, 58, 0};
    localparam int unsigned         RecvIdle     [NumPhases] = '{58, 58, 11, 11, 0};

    // Ways a generated frame can be damaged
    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_FIXED,
        FLAW_CMD,
        FLAW_SUM,
        FLAW_CUT
    } flaw_t;

    // One pending byte, or a marker that holds the sender until all results are back
    typedef struct packed {
        logic       wait_drain;
        logic [7:0] rx;
    } byte_slot_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [23:0]         m_tdata;
    logic [2:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;

    // Register mirror and frame tracker state
    logic [2:0]       cfg_profile = '0;
    logic             cfg_accept  = 1'b0;
    logic [PosW-1:0]  hunt_pos    = '0;
    logic [SizeW-1:0] frame_len   = '0;
    logic [7:0]       sum_acc     = '0;
    logic             fixed_bad   = 1'b0;
    logic             cmd_bad     = 1'b0;

    byte_slot_t  byte_q [$];
    result_t     verdict_q [$];
    int unsigned pushed_count = 0;
    int unsigned in_count     = 0;
    int unsigned out_count    = 0;
    int unsigned err_count    = 0;
    int unsigned quiet        = 0;
    int unsigned hold_left    = 0;
    int unsigned hold_idx     = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};
    int unsigned reason_seen [8] = '{0, 0, 0, 0, 0, 0, 0, 0};
    logic        s_took = 1'b0;

    status_frame_receiver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Drop back to hunting for a header
    function automatic void clear_frame();
        hunt_pos  = '0;
        frame_len = '0;
        sum_acc   = '0;
        fixed_bad = 1'b0;
        cmd_bad   = 1'b0;
    endfunction

    // Advance the frame tracker by one byte and return the verdict beat it causes
    function automatic result_t judge_byte(logic [7:0] rx);
        result_t          r;
        logic [SizeW-1:0] nxt;
        logic [SizeW-1:0] len;
        logic             ended;
        r.status        = ST_NONE;
        r.reject_reason = RSN_NONE;
        r.in_frame      = 1'b0;
        r.byte_index    = '0;
        r.data_out      = rx;
        ended           = 1'b0;
        if (hunt_pos == '0) begin
            if (rx == HdrByte) begin
                clear_frame();
                hunt_pos   = 8'd1;
                sum_acc    = HdrByte;
                r.in_frame = 1'b1;
            end
        end else begin
            nxt          = {1'b0, hunt_pos} + 9'd1;
            r.in_frame   = 1'b1;
            r.byte_index = hunt_pos[IndexW-1:0];
            if ((hunt_pos == OffVersion && rx != FixedOne) ||
                (hunt_pos == OffPad && rx != FixedZero) ||
                (hunt_pos == OffKind && rx != FixedFour) ||
                (hunt_pos == OffKindPad && rx != FixedZero))
                fixed_bad = 1'b1;
            // Responses pass on any non-basic profile or when explicitly allowed
            if (hunt_pos == OffCommand && rx != CmdStatus &&
                !(rx == CmdResponse && (cfg_profile != '0 || cfg_accept)))
                cmd_bad = 1'b1;
            if (hunt_pos == OffLength) begin
                len = {1'b0, rx} + LenExtra;
                if (len < MinSize || len > MaxSize) begin
                    clear_frame();
                    r.status = ST_ABORT;
                    ended    = 1'b1;
                end else begin
                    frame_len = len;
                end
            end
            if (!ended) begin
                if (frame_len != '0 && nxt == frame_len) begin
                    // Size first, then fixed bytes, command, checksum
                    if (!(frame_len == SizeA || frame_len == SizeB || frame_len == SizeC))
                        r.reject_reason = RSN_SIZE;
                    else if (fixed_bad)
                        r.reject_reason = RSN_FIXED;
                    else if (cmd_bad)
                        r.reject_reason = RSN_COMMAND;
                    else if (sum_acc != rx)
                        r.reject_reason = RSN_CHECKSUM;
                    r.status = (r.reject_reason == RSN_NONE) ? ST_GOOD : ST_REJECT;
                    clear_frame();
                end else begin
                    sum_acc  = sum_acc ^ rx;
                    hunt_pos = nxt[PosW-1:0];
                end
            end
        end
        return r;
    endfunction

    task automatic note_fail(string msg);
        err_count++;
        if (err_count <= ReportMax)
            $display("%0t ERROR: %s", $realtime, msg);
    endtask

    task automatic push_byte(logic [7:0] rx);
        byte_slot_t slot;
        slot.wait_drain = 1'b0;
        slot.rx         = rx;
        byte_q.push_back(slot);
        pushed_count++;
    endtask

    task automatic push_drain();
        byte_slot_t slot;
        slot.wait_drain = 1'b1;
        slot.rx         = '0;
        byte_q.push_back(slot);
    endtask

    // Header, fixed bytes, a random command and an out-of-range length
    task automatic add_abort(logic [7:0] len);
        push_byte(HdrByte);
        push_byte(FixedOne);
        push_byte(FixedZero);
        push_byte(8'($urandom_range(255)));
        push_byte(len);
    endtask

    // Build a whole frame of the given size, then damage it as asked
    task automatic add_frame(int unsigned size, logic [7:0] cmd, flaw_t flaw);
        logic [7:0]  fr [0:BufferBytes-1];
        logic [7:0]  x;
        int unsigned k;
        int unsigned cut;
        fr[0]          = HdrByte;
        fr[OffVersion] = FixedOne;
        fr[OffPad]     = FixedZero;
        fr[OffCommand] = cmd;
        fr[OffLength]  = 8'(size - LenExtra);
        fr[OffKind]    = FixedFour;
        fr[OffKindPad] = FixedZero;
        for (k = 7; k + 1 < size; k++)
            fr[k] = 8'($urandom_range(255));
        if (flaw == FLAW_CMD) begin
            do fr[OffCommand] = 8'($urandom_range(255));
            while (fr[OffCommand] == CmdStatus || fr[OffCommand] == CmdResponse);
        end
        if (flaw == FLAW_FIXED) begin
            case ($urandom_range(3))
                0: k = OffVersion;
                1: k = OffPad;
                2: k = OffKind;
                default: k = OffKindPad;
            endcase
            fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
        end
        x = '0;
        for (k = 0; k + 1 < size; k++)
            x = x ^ fr[k];
        fr[size-1] = x;
        if (flaw == FLAW_SUM)
            fr[size-1] = x ^ 8'($urandom_range(1, 255));
        cut = (flaw == FLAW_CUT) ? $urandom_range(1, size - 1) : size;
        for (k = 0; k < cut; k++)
            push_byte(fr[k]);
    endtask

    // Random frames of supported and other sizes, some damaged, plus length aborts and noise
    task automatic add_random(int unsigned budget);
        int unsigned start;
        int unsigned pick;
        int unsigned k;
        logic        drained;
        logic [7:0]  cmd;
        logic [7:0]  rx;
        flaw_t       flaw;
        start   = pushed_count;
        drained = 1'b0;
        while (pushed_count - start < budget) begin
            pick = $urandom_range(99);
            k    = $urandom_range(99);
            flaw = (k < 40) ? FLAW_NONE : (k < 55) ? FLAW_FIXED :
                   (k < 70) ? FLAW_CMD : (k < 90) ? FLAW_SUM : FLAW_CUT;
            k    = $urandom_range(99);
            cmd  = (k < 45) ? CmdStatus : (k < 85) ? CmdResponse : 8'($urandom_range(255));
            if (pick < 55) begin
                case ($urandom_range(2))
                    0: add_frame(SizeA, cmd, flaw);
                    1: add_frame(SizeB, cmd, flaw);
                    default: add_frame(SizeC, cmd, flaw);
                endcase
            end else if (pick < 80) begin
                add_frame($urandom_range(MinSize, 24), cmd, flaw);
            end else if (pick < 83) begin
                add_frame($urandom_range(25, BufferBytes), cmd, flaw);
            end else if (pick < 92) begin
                if ($urandom_range(1))
                    add_abort(8'($urandom_range(1)));
                else
                    add_abort(8'($urandom_range(BufferBytes - LenExtra + 1, 255)));
            end else begin
                for (k = $urandom_range(1, 6); k != 0; k--) begin
                    do rx = 8'($urandom_range(255));
                    while (rx == HdrByte);
                    push_byte(rx);
                end
            end
            if (!drained) begin
                push_drain();
                drained = 1'b1;
            end
        end
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        if (idx == CfgDeviceProfile)
            cfg_profile = val[2:0];
        else
            cfg_accept = val[0];
    endtask

    // Wait until every byte is taken and every verdict is back
    task automatic settle();
        while (in_count != pushed_count || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SettleGap) @(posedge aclk);
    endtask

    // Stimulus and phase control
    initial begin
        int unsigned ph;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (ph = 0; ph < NumPhases; ph++) begin
            settle();
            write_reg(CfgDeviceProfile, PhaseProfile[ph]);
            write_reg(CfgAcceptResponse, PhaseAccept[ph]);
            @(negedge aclk);
            cfg_valid     <= 1'b0;
            send_idle_pct <= SendIdle[ph];
            recv_idle_pct <= RecvIdle[ph];
            if (ph == 0) begin
                // Non-header bytes while hunting, length aborts on both sides
                push_byte(8'h00);
                push_byte(8'hFF);
                push_byte(8'h5A);
                add_abort(8'd0);
                add_abort(8'd1);
                add_abort(8'(BufferBytes - LenExtra + 1));
                add_abort(8'hFF);
                add_frame(MinSize, CmdStatus, FLAW_NONE);
            end
            if (ph == NumPhases - 1)
                add_frame(BufferBytes, CmdStatus, FLAW_NONE);
            add_random(PhaseBytes);
        end
        settle();
        repeat (TailCycles) @(posedge aclk);
        $display("Run covered %0d bytes over %0d register settings: %0d good, %0d aborted",
                 in_count, NumPhases, status_seen[ST_GOOD], status_seen[ST_ABORT]);
        $display("Rejects by size %0d, fixed byte %0d, command %0d, checksum %0d",
                 reason_seen[RSN_SIZE], reason_seen[RSN_FIXED],
                 reason_seen[RSN_COMMAND], reason_seen[RSN_CHECKSUM]);
        if (err_count == 0 && verdict_q.size() == 0 && out_count == in_count)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Byte sender: advance once the current beat is taken
    always @(negedge aclk) begin
        byte_slot_t head;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (byte_q.size() != 0 && byte_q[0].wait_drain) begin
                s_tvalid <= 1'b0;
                if (verdict_q.size() == 0)
                    void'(byte_q.pop_front());
            end else if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                head = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= head.rx;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus long hold-offs to back up the input
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_idx < 2 && in_count >= HoldAt[hold_idx]) begin
            m_tready  <= 1'b0;
            hold_left <= LongHold;
            hold_idx  <= hold_idx + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check result beats against the oldest verdict, then predict for new bytes
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                out_count++;
                got.status        = status_t'(m_tuser[1:0]);
                got.in_frame      = m_tuser[2];
                got.reject_reason = reason_t'(m_tdata[2:0]);
                got.byte_index    = m_tdata[9:3];
                got.data_out      = m_tdata[17:10];
                if (verdict_q.size() == 0) begin
                    note_fail($sformatf("result beat with nothing pending, data %h", got.data_out));
                end else begin
                    want = verdict_q.pop_front();
                    if (got.status !== want.status || got.reject_reason !== want.reject_reason ||
                        got.in_frame !== want.in_frame || got.byte_index !== want.byte_index ||
                        got.data_out !== want.data_out)
                        note_fail($sformatf({"beat %0d exp st %0d rsn %0d inf %0d idx %0d d %h",
                                             " / got st %0d rsn %0d inf %0d idx %0d d %h"},
                                            out_count, want.status, want.reject_reason,
                                            want.in_frame, want.byte_index, want.data_out,
                                            got.status, got.reject_reason, got.in_frame,
                                            got.byte_index, got.data_out));
                end
            end
            if (s_tvalid && s_tready) begin
                in_count++;
                want = judge_byte(s_tdata);
                status_seen[want.status]++;
                reason_seen[want.reject_reason]++;
                verdict_q.push_back(want);
            end
        end
    end

    // Watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet <= 0;
            end else if (quiet >= StallLimit) begin
                $display("Timeout after %0d idle cycles", quiet);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

endmodule

// ----- filelist.f -----
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_cfg.sv
hw/rtl/sfr_parser.sv
hw/rtl/status_frame_receiver.sv
sim/tb.sv
